FILE: rtl/assert_macros.svh
// Assertion macros used by the checker module of the panel controller.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define PHT_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while rst is high.
`define PHT_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/pht_pkg.sv
// Types and constants of the panel hold-toggle timeout controller.
// No dependencies; imported by every module of the block.
package pht_pkg;

  localparam int HOLD_W = 4;
  localparam int AUTO_W = 10;
  localparam int CMD_W = 8;
  localparam int BTN_N = 5;
  localparam int TURNOUT_N = 5;
  localparam int SIGNAL_N = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AUTO_OFF   = 2'd1;

  localparam logic [HOLD_W-1:0] HOLD_TICKS_RESET = 4'd3;
  localparam logic [AUTO_W-1:0] AUTO_OFF_RESET   = 10'd120;

  localparam logic [CMD_W-1:0] CMD_SET_T0      = 8'd1;
  localparam logic [CMD_W-1:0] CMD_SET_T1      = 8'd2;
  localparam logic [CMD_W-1:0] CMD_SET_T2      = 8'd3;
  localparam logic [CMD_W-1:0] CMD_CLR_T3_SET4 = 8'd4;
  localparam logic [CMD_W-1:0] CMD_CLR_T0      = 8'd5;
  localparam logic [CMD_W-1:0] CMD_CLR_T1      = 8'd6;
  localparam logic [CMD_W-1:0] CMD_CLR_T2      = 8'd7;
  localparam logic [CMD_W-1:0] CMD_SET_T3_CLR4 = 8'd8;

  typedef struct packed {
    logic             tick;
    logic [CMD_W-1:0] command;
    logic [BTN_N-1:0] pressed;
  } poll_t;

  typedef struct packed {
    logic [TURNOUT_N-1:0] turnouts;
    logic [SIGNAL_N-1:0]  signal_relays;
    logic                 shunt_relay;
    logic                 shunt_led;
  } result_t;

endpackage

FILE: rtl/pht_hold_qual.sv
// Qualifier for one panel button: fires at most once per press after the hold time.
// Depends on pht_pkg.
module pht_hold_qual
  import pht_pkg::*;
#(
  parameter int TICKS_PER_SECOND = 10
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       step,
  input  logic                                       held,
  input  logic [$clog2(TICKS_PER_SECOND + 16)-1:0]   tenth,
  input  logic [HOLD_W-1:0]                          hold_ticks,
  output logic                                       fire
);

  localparam int TW = $clog2(TICKS_PER_SECOND + 16);
  localparam logic [TW-1:0] TPS_V = TW'(TICKS_PER_SECOND);

  logic          armed;
  logic          pending;
  logic [TW-1:0] target;
  logic          armed_next;
  logic          pending_next;
  logic [TW-1:0] target_next;
  logic [TW-1:0] sum;
  logic [TW-1:0] new_target;
  logic [TW-1:0] tgt;
  logic          pend;

  always_comb begin
    sum = tenth + TW'(hold_ticks);
    new_target = (sum >= TPS_V) ? sum - TPS_V : sum;
    tgt = armed ? target : new_target;
    pend = armed ? pending : 1'b1;
    fire = held && pend && (tenth == tgt);
    if (held) begin
      armed_next = 1'b1;
      pending_next = pend && !fire;
      target_next = tgt;
    end else begin
      armed_next = 1'b0;
      pending_next = 1'b0;
      target_next = target;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed <= 1'b0;
      pending <= 1'b0;
    end else if (step) begin
      armed <= armed_next;
      pending <= pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      target <= target_next;
    end
  end

endmodule

FILE: rtl/panel_hold_toggle_timeout_controller.sv
// Top level of the panel hold-toggle timeout controller: counters, turnouts, relays.
// Depends on pht_pkg and pht_hold_qual.
//
//   channel  | signals                          | direction
//   poll     | poll_valid, poll_stall, poll     | request in
//   result   | result_valid, result_stall, result | request out
//   cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data | register write in
//
// One poll per clock sustained while results are not stalled.
// The poll register and the result register together buffer two requests.
// poll_stall rises only while both registers are full and result_stall is high.
// rst clears counters, qualifiers, timer and outputs, and restores the register defaults.
// cfg_ready is always high; writes take effect at the next edge.
module panel_hold_toggle_timeout_controller
  import pht_pkg::*;
#(
  parameter int TICKS_PER_SECOND = 10,
  parameter int SECONDS_WRAP = 600
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 poll_valid,
  output logic                 poll_stall,
  input  poll_t                poll,
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_t              result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [AUTO_W-1:0]    cfg_data
);

  localparam int TW = $clog2(TICKS_PER_SECOND + 16);
  localparam int SW = $clog2(SECONDS_WRAP + 1024);
  localparam logic [TW-1:0] TPS_V = TW'(TICKS_PER_SECOND);
  localparam logic [SW-1:0] WRAP_V = SW'(SECONDS_WRAP);

  logic [HOLD_W-1:0] hold_ticks;
  logic [AUTO_W-1:0] auto_off_seconds;

  poll_t   poll_q;
  logic    poll_q_valid;
  logic    advance;

  logic [TW-1:0] tenth_count;
  logic [TW-1:0] tenth_next;
  logic [TW-1:0] tenth_inc;
  logic [SW-1:0] second_count;
  logic [SW-1:0] second_next;
  logic [SW-1:0] second_inc;
  logic [SW-1:0] release_target;
  logic [SW-1:0] release_target_next;
  logic          release_armed;
  logic          release_armed_next;
  logic [SW-1:0] release_sum;
  logic [SW-1:0] release_tgt;
  logic [BTN_N-1:0] fire;

  result_t outs;
  result_t outs_next;

  assign cfg_ready = 1'b1;
  assign advance = poll_q_valid && (!result_valid || !result_stall);
  assign poll_stall = poll_q_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_ticks <= HOLD_TICKS_RESET;
      auto_off_seconds <= AUTO_OFF_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HOLD_TICKS: hold_ticks <= cfg_data[HOLD_W-1:0];
        REG_AUTO_OFF:   auto_off_seconds <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_q_valid <= 1'b0;
    end else if (!poll_stall) begin
      poll_q_valid <= poll_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!poll_stall) begin
      poll_q <= poll;
    end
  end

  always_comb begin
    tenth_inc = tenth_count + TW'(poll_q.tick);
    second_inc = second_count + SW'(1);
    if (tenth_inc >= TPS_V) begin
      tenth_next = '0;
      second_next = (second_inc >= WRAP_V) ? '0 : second_inc;
    end else begin
      tenth_next = tenth_inc;
      second_next = second_count;
    end
  end

  for (genvar b = 0; b < BTN_N; b++) begin : g_qual
    pht_hold_qual #(
      .TICKS_PER_SECOND(TICKS_PER_SECOND)
    ) u_qual (
      .clk       (clk),
      .rst       (rst),
      .step      (advance),
      .held      (poll_q.pressed[b]),
      .tenth     (tenth_next),
      .hold_ticks(hold_ticks),
      .fire      (fire[b])
    );
  end

  always_comb begin
    outs_next = outs;
    case (poll_q.command)
      CMD_SET_T0:      outs_next.turnouts[0] = 1'b1;
      CMD_SET_T1:      outs_next.turnouts[1] = 1'b1;
      CMD_SET_T2:      outs_next.turnouts[2] = 1'b1;
      CMD_CLR_T3_SET4: begin
        outs_next.turnouts[3] = 1'b0;
        outs_next.turnouts[4] = 1'b1;
      end
      CMD_CLR_T0:      outs_next.turnouts[0] = 1'b0;
      CMD_CLR_T1:      outs_next.turnouts[1] = 1'b0;
      CMD_CLR_T2:      outs_next.turnouts[2] = 1'b0;
      CMD_SET_T3_CLR4: begin
        outs_next.turnouts[3] = 1'b1;
        outs_next.turnouts[4] = 1'b0;
      end
      default: ;
    endcase

    if (fire[0]) begin
      outs_next.shunt_relay = !outs_next.shunt_relay;
      outs_next.shunt_led = !outs_next.shunt_led;
      outs_next.signal_relays = '0;
    end
    for (int s = 0; s < SIGNAL_N; s++) begin
      if (fire[s+1]) begin
        outs_next.signal_relays[s] = !outs_next.signal_relays[s];
        outs_next.shunt_relay = 1'b0;
        outs_next.shunt_led = 1'b0;
      end
    end

    release_sum = second_next + SW'(auto_off_seconds);
    release_tgt = release_armed ? release_target
                : ((release_sum >= WRAP_V) ? release_sum - WRAP_V : release_sum);
    if (outs_next.shunt_relay) begin
      release_armed_next = 1'b1;
      release_target_next = release_tgt;
      if (second_next == release_tgt) begin
        outs_next.shunt_relay = 1'b0;
      end
    end else begin
      release_armed_next = 1'b0;
      release_target_next = release_target;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tenth_count <= '0;
      second_count <= '0;
      release_armed <= 1'b0;
      release_target <= '0;
      outs <= '0;
    end else if (advance) begin
      tenth_count <= tenth_next;
      second_count <= second_next;
      release_armed <= release_armed_next;
      release_target <= release_target_next;
      outs <= outs_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= outs_next;
    end
  end

endmodule

FILE: rtl/pht_checker.sv
// Port-level checks of the panel controller, bound to the top level.
// Depends on pht_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pht_checker
  import pht_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 poll_valid,
  input logic                 poll_stall,
  input poll_t                poll,
  input logic                 result_valid,
  input logic                 result_stall,
  input result_t              result,
  input logic                 cfg_valid,
  input logic                 cfg_ready,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [AUTO_W-1:0]    cfg_data
);

  logic out_wait;
  logic shunt_on;
  logic signal_on;

  assign out_wait = result_valid && result_stall;
  assign shunt_on = result.shunt_relay || result.shunt_led;
  assign signal_on = |result.signal_relays;

  `PHT_ASSERT_NXT(a_result_hold, clk, rst, out_wait, result_valid && $stable(result), "stalled result changed")
  `PHT_ASSERT_NXT(a_reset_empty, clk, 1'b0, rst, !result_valid && !poll_stall, "busy after reset")
  `PHT_ASSERT_IMP(a_stall_cause, clk, rst, poll_stall, out_wait, "poll stalled without cause")
  `PHT_ASSERT_IMP(a_shunt_excl, clk, rst, result_valid, !(shunt_on && signal_on), "shunt and signal on")

endmodule

bind panel_hold_toggle_timeout_controller pht_checker u_pht_checker (.*);
